// ===== sv/fifo_queue_with_prefix_reverse_macros.svh =====
// ----------------------------------------------------------------------------
// FIFO queue with prefix reverse - assertion macros
// Shared property wrappers for the checker; clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_PREFIX_REVERSE_MACROS_SVH
`define FIFO_QUEUE_WITH_PREFIX_REVERSE_MACROS_SVH

// Same-cycle implication.
`define FQPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FQPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fqpr_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO queue with prefix reverse - package
// Field widths, opcode and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fqpr_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int K_W      = 5;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 5;
    localparam int SWAP_W   = K_W - 1;

    typedef logic [OP_W-1:0]            opcode_t;
    typedef logic signed [DATA_W-1:0]   data_t;
    typedef logic [STATUS_W-1:0]        status_t;

    localparam opcode_t OP_PUSH    = 3'd0;
    localparam opcode_t OP_POP     = 3'd1;
    localparam opcode_t OP_PEEK    = 3'd2;
    localparam opcode_t OP_SIZE    = 3'd3;
    localparam opcode_t OP_REVERSE = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic swap_go;
        logic last_swap;
        logic out_free;
    } stat_t;

endpackage

// ===== sv/fqpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// FIFO queue with prefix reverse - controller
// Sequences one request at a time: execute, swap loop, result hand-off.
// ----------------------------------------------------------------------------
module fqpr_ctrl
    import fqpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.swap_go ? S_RD_A : S_DONE;
            end
            S_RD_A: state_next = S_RD_B;
            S_RD_B: state_next = S_WR_A;
            S_WR_A: state_next = S_WR_B;
            S_WR_B:
            begin
                state_next = stat.last_swap ? S_DONE : S_RD_A;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = in_valid ? S_EXEC : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        case (state_reg)
            S_IDLE: in_stall = 1'b0;
            S_EXEC: cmd.exec = 1'b1;
            S_RD_A: cmd.rd_a = 1'b1;
            S_RD_B: cmd.rd_b = 1'b1;
            S_WR_A: cmd.wr_a = 1'b1;
            S_WR_B: cmd.wr_b = 1'b1;
            S_DONE:
            begin
                cmd.load_out = stat.out_free;
                in_stall     = !stat.out_free;
            end
            default: in_stall = 1'b1;
        endcase
        accept      = in_valid && !in_stall;
        cmd.capture = accept;
    end

endmodule

// ===== sv/fqpr_datapath.sv =====
// ----------------------------------------------------------------------------
// FIFO queue with prefix reverse - datapath
// Ring buffer store, head/count, swap walker and the result register.
// ----------------------------------------------------------------------------
module fqpr_datapath
    import fqpr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [OP_W-1:0]     opcode,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic [K_W-1:0]      prefix_length,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic signed [DATA_W-1:0] data_out,
    output logic [SIZE_W-1:0]   size_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OFF_W = (CNT_W > K_W) ? CNT_W : K_W;
    localparam int SUM_W = OFF_W + 1;

    data_t mem [DEPTH];

    // request registers
    opcode_t          op_reg;
    data_t            value_reg;
    logic [K_W-1:0]   k_reg;

    // queue control state
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // swap walker
    logic [SWAP_W-1:0] i_reg;
    data_t             tmp_reg;
    data_t             rd_data_reg;

    // pending result
    status_t res_status_reg;
    status_t res_status_next;
    logic    res_read_reg;
    logic    res_read_next;

    logic    out_valid_reg;
    logic    out_valid_next;
    status_t status_reg;
    data_t   data_reg;
    logic [SIZE_W-1:0] size_reg;

    // memory port
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_addr;
    data_t            mem_wdata;

    logic             full;
    logic             empty;
    logic             k_range;
    logic [OFF_W-1:0] off_b;
    logic [IDX_W-1:0] slot_a;
    logic [IDX_W-1:0] slot_b;
    logic [OFF_W-1:0] cnt_ext;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [OFF_W-1:0] off);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(head) + SUM_W'(off);
            if (sum >= SUM_W'(DEPTH))
            begin
                sum = sum - SUM_W'(DEPTH);
            end
            return sum[IDX_W-1:0];
        end
    endfunction

    always_comb
    begin
        full    = (count_reg == CNT_W'(DEPTH));
        empty   = (count_reg == '0);
        k_range = (OFF_W'(k_reg) > OFF_W'(count_reg));
        off_b   = OFF_W'(k_reg) - OFF_W'(i_reg) - OFF_W'(1);
        slot_a  = slot_of(head_reg, OFF_W'(i_reg));
        slot_b  = slot_of(head_reg, off_b);
        cnt_ext = OFF_W'(count_reg);

        stat.swap_go   = (op_reg == OP_REVERSE) && !k_range && (k_reg[K_W-1:1] != '0);
        stat.last_swap = ((i_reg + SWAP_W'(1)) == k_reg[K_W-1:1]);
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // execute step, swap-loop memory traffic and the result valid flag
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = slot_a;
        mem_wdata       = rd_data_reg;

        if (cmd.exec)
        begin
            res_status_next = ST_OK;
            res_read_next   = 1'b0;
            case (op_reg)
                OP_PUSH:
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = slot_of(head_reg, cnt_ext);
                        mem_wdata  = value_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    if (empty)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        mem_addr      = head_reg;
                        res_read_next = 1'b1;
                        if (op_reg == OP_POP)
                        begin
                            head_next  = slot_of(head_reg, OFF_W'(1));
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_REVERSE:
                begin
                    if (k_range)
                    begin
                        res_status_next = ST_RANGE;
                    end
                end
                default: res_status_next = ST_OK;
            endcase
        end
        else if (cmd.rd_a)
        begin
            mem_re   = 1'b1;
            mem_addr = slot_a;
        end
        else if (cmd.rd_b)
        begin
            mem_re   = 1'b1;
            mem_addr = slot_b;
        end
        else if (cmd.wr_a)
        begin
            mem_we    = 1'b1;
            mem_addr  = slot_a;
            mem_wdata = rd_data_reg;
        end
        else if (cmd.wr_b)
        begin
            mem_we    = 1'b1;
            mem_addr  = slot_b;
            mem_wdata = tmp_reg;
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            value_reg <= push_value;
            k_reg     <= prefix_length;
        end
        if (cmd.exec)
        begin
            i_reg <= '0;
        end
        else if (cmd.wr_b)
        begin
            i_reg <= i_reg + SWAP_W'(1);
        end
        if (cmd.rd_b)
        begin
            tmp_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            status_reg <= res_status_reg;
            data_reg   <= res_read_reg ? rd_data_reg : '0;
            size_reg   <= cnt_ext[SIZE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign size_out  = size_reg;

endmodule

// ===== sv/fifo_queue_with_prefix_reverse.sv =====
// Flow: a request passes through the execute and done states to the result
//   register; an in-range prefix reverse of k entries adds floor(k/2) swaps.
// Requests: one in flight; the next is taken as the result is loaded. Each
//   swap is read, read, write, write on the single port of the entry store.
// Reset: rst_n is asynchronous, active low; it empties the queue (head and
//   count to zero) and drops any pending result. Entry store is not cleared.
// ----------------------------------------------------------------------------
// FIFO queue with prefix reverse - top level
// Bounded ring-buffer FIFO of signed words with push, pop, peek, size and
// in-place reversal of the first k entries; one result per request.
// ----------------------------------------------------------------------------
module fifo_queue_with_prefix_reverse
    import fqpr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic [K_W-1:0]           prefix_length,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic signed [DATA_W-1:0] data_out,
    output logic [SIZE_W-1:0]        size_out
);

    cmd_t  cmd;
    stat_t stat;

    // Controller: one request in flight. It takes the next request in the
    // same cycle it hands the current result to the result register, so a
    // result that waits on out_stall does not hold up the request side
    // until the following result is due.
    fqpr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: entry store with registered read, head/count, the swap
    // walker for reverse, and the result register that drives the outputs.
    // Empty pop/peek, full push and out-of-range reverse leave state alone
    // and only flag the status.
    fqpr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .push_value    (push_value),
        .prefix_length (prefix_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .data_out      (data_out),
        .size_out      (size_out)
    );

endmodule

// ===== sv/fqpr_checker.sv =====
// ----------------------------------------------------------------------------
// FIFO queue with prefix reverse - port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_prefix_reverse_macros.svh"

module fqpr_checker
    import fqpr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [OP_W-1:0]          opcode,
    input logic signed [DATA_W-1:0] push_value,
    input logic [K_W-1:0]           prefix_length,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [STATUS_W-1:0]      status,
    input logic signed [DATA_W-1:0] data_out,
    input logic [SIZE_W-1:0]        size_out
);

    localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(DEPTH);

    logic [STATUS_W+DATA_W+SIZE_W-1:0] result_bus;
    logic [OP_W+DATA_W+K_W-1:0]        request_bus;
    logic                              out_wait;
    logic                              in_wait;
    logic                              in_take;
    logic                              empty_seen;
    logic                              full_seen;
    logic                              data_zero;
    logic                              size_zero;
    logic                              size_full;

    assign result_bus  = {status, data_out, size_out};
    assign request_bus = {opcode, push_value, prefix_length};
    assign out_wait    = out_valid && out_stall;
    assign in_wait     = in_valid && in_stall;
    assign in_take     = in_valid && !in_stall;
    assign empty_seen  = out_valid && (status == ST_EMPTY);
    assign full_seen   = out_valid && (status == ST_FULL);
    assign data_zero   = (data_out == '0);
    assign size_zero   = (size_out == '0);
    assign size_full   = (size_out == FULL_SIZE);

    `FQPR_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(result_bus), "held result moved")
    `FQPR_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(request_bus), "held request moved")
    `FQPR_ASSERT_NEXT(a_one_in_flight, in_take, in_stall, "request taken twice in a row")
    `FQPR_ASSERT_NOW(a_empty_result, empty_seen, data_zero && size_zero, "bad empty result")
    `FQPR_ASSERT_NOW(a_full_result, full_seen, data_zero && size_full, "bad full result")

endmodule

bind fifo_queue_with_prefix_reverse fqpr_checker #(.DEPTH(DEPTH)) u_fqpr_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIFO queue with prefix reverse - testbench
// Drives push, pop, peek, size, prefix-reverse and spare-opcode requests
// through the valid/stall request channel. A shadow ring buffer predicts
// the result of each request, and every result is checked in order. A
// short table of directed requests comes first. Phased random traffic
// follows: fill, drain and churn phases, with bursty sending, patterned
// result stalls and long result hold-offs.
// ----------------------------------------------------------------------------
module testbench;
    import fqpr_pkg::*;

    localparam int QUEUE_DEPTH     = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int CYCLE_LIMIT     = 400000;
    // The longest request is a full-length reverse.
    localparam int SETTLE_CYCLES   = 2 * (2 + 4 * (QUEUE_DEPTH / 2));
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int FIRST_HOLD_AT   = 200;
    localparam int SECOND_HOLD_AT  = 700;
    localparam int ROW_COUNT       = 22;

    // Opcodes outside the defined set; the block must ignore them.
    localparam opcode_t OP_SPARE_LO = 3'd5;
    localparam opcode_t OP_SPARE_HI = 3'd7;

    typedef struct packed {
        status_t             status;
        data_t               data;
        logic [SIZE_W-1:0]   size;
    } queue_outcome_t;

    // One directed row: a request, how many times to repeat it (the word
    // steps by one on each repeat), and an optional hand-typed outcome.
    typedef struct packed {
        opcode_t             op;
        data_t               word;
        logic [K_W-1:0]      k;
        logic [4:0]          reps;
        logic                typed;
        queue_outcome_t      outcome;
    } stim_row_t;

    typedef enum logic [1:0] {
        FILL_PHASE,
        DRAIN_PHASE,
        CHURN_PHASE
    } traffic_phase_t;

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode        = OP_SIZE;
    logic signed [DATA_W-1:0] push_value    = '0;
    logic [K_W-1:0]           prefix_length = '0;
    logic                     out_valid;
    logic                     out_stall     = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_out;
    logic [SIZE_W-1:0]        size_out;

    // Shadow copy of the queue, updated as each request is accepted.
    data_t                    shadow_words [QUEUE_DEPTH];
    int                       shadow_head  = 0;
    int                       shadow_count = 0;

    queue_outcome_t           awaited_outcomes [$];
    int                       outcomes_checked = 0;
    int                       mismatch_count   = 0;
    int                       burst_left       = 0;
    int                       cycle_count      = 0;

    // Directed requests. Rows with typed = 1 carry an outcome that can be read
    // straight off the queue contents; the others rely on the shadow queue.
    stim_row_t directed_rows [ROW_COUNT] = '{
        // pop and peek on an empty queue
        '{OP_POP,      '0,             5'd0,  5'd1,  1'b1, '{ST_EMPTY, '0, 5'd0}},
        '{OP_PEEK,     '0,             5'd0,  5'd1,  1'b1, '{ST_EMPTY, '0, 5'd0}},
        // zero-length reverse is a no-op, any other length is out of range
        '{OP_REVERSE,  '0,             5'd0,  5'd1,  1'b1, '{ST_OK,    '0, 5'd0}},
        '{OP_REVERSE,  '0,             5'd1,  5'd1,  1'b1, '{ST_RANGE, '0, 5'd0}},
        '{OP_SPARE_HI, -32'sd1,        5'd31, 5'd1,  1'b1, '{ST_OK,    '0, 5'd0}},
        // extreme words
        '{OP_PUSH,     32'sh7FFF_FFFF, 5'd0,  5'd1,  1'b1, '{ST_OK,    '0, 5'd1}},
        '{OP_PUSH,     32'sh8000_0000, 5'd31, 5'd1,  1'b1, '{ST_OK,    '0, 5'd2}},
        '{OP_PUSH,     -32'sd1,        5'd0,  5'd1,  1'b1, '{ST_OK,    '0, 5'd3}},
        '{OP_PUSH,     '0,             5'd0,  5'd1,  1'b1, '{ST_OK,    '0, 5'd4}},
        '{OP_PEEK,     '0,             5'd0,  5'd1,  1'b1,
            '{ST_OK, 32'sh7FFF_FFFF, 5'd4}},
        // reverse the whole queue, so zero comes to the front
        '{OP_REVERSE,  '0,             5'd4,  5'd1,  1'b1, '{ST_OK,    '0, 5'd4}},
        '{OP_POP,      '0,             5'd0,  5'd1,  1'b1, '{ST_OK,    '0, 5'd3}},
        '{OP_REVERSE,  '0,             5'd31, 5'd1,  1'b1, '{ST_RANGE, '0, 5'd3}},
        // fill up, then push into a full queue
        '{OP_PUSH,     32'sh0000_0100, 5'd0,  5'd13, 1'b0, '0},
        '{OP_PUSH,     32'sh5A5A_5A5A, 5'd0,  5'd1,  1'b1, '{ST_FULL,  '0, 5'd16}},
        '{OP_REVERSE,  '0,             5'd16, 5'd1,  1'b0, '0},
        '{OP_REVERSE,  '0,             5'd17, 5'd1,  1'b1, '{ST_RANGE, '0, 5'd16}},
        '{OP_POP,      '0,             5'd0,  5'd2,  1'b0, '0},
        '{OP_SPARE_LO, '0,             5'd0,  5'd1,  1'b1, '{ST_OK,    '0, 5'd14}},
        '{OP_PUSH,     32'sh5555_5555, 5'd0,  5'd1,  1'b1, '{ST_OK,    '0, 5'd15}},
        // the head has moved, so this reverse wraps past the end of storage
        '{OP_REVERSE,  '0,             5'd15, 5'd1,  1'b0, '0},
        '{OP_PEEK,     '0,             5'd0,  5'd1,  1'b0, '0}
    };

    fifo_queue_with_prefix_reverse #(
        .DEPTH         (QUEUE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .push_value    (push_value),
        .prefix_length (prefix_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .data_out      (data_out),
        .size_out      (size_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Keep reset asserted at the start, then release it for good.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one request to the shadow queue and return the outcome it yields.
    function automatic queue_outcome_t advance_queue(input opcode_t op, input data_t word,
                                                     input logic [K_W-1:0] k);
        queue_outcome_t result;
        int             lo_slot;
        int             hi_slot;
        data_t          held;
        result.status = ST_OK;
        result.data   = '0;
        case (op)
            OP_PUSH:
            begin
                if (shadow_count >= QUEUE_DEPTH)
                    result.status = ST_FULL;
                else
                begin
                    shadow_words[(shadow_head + shadow_count) % QUEUE_DEPTH] = word;
                    shadow_count++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (shadow_count == 0)
                    result.status = ST_EMPTY;
                else
                begin
                    result.data = shadow_words[shadow_head];
                    if (op == OP_POP)
                    begin
                        shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
                        shadow_count--;
                    end
                end
            end
            OP_REVERSE:
            begin
                if (int'(k) > shadow_count)
                    result.status = ST_RANGE;
                else
                begin
                    // Swap outside-in over the first k entries from the head.
                    for (int i = 0; i < int'(k) / 2; i++)
                    begin
                        lo_slot = (shadow_head + i) % QUEUE_DEPTH;
                        hi_slot = (shadow_head + int'(k) - 1 - i) % QUEUE_DEPTH;
                        held = shadow_words[lo_slot];
                        shadow_words[lo_slot] = shadow_words[hi_slot];
                        shadow_words[hi_slot] = held;
                    end
                end
            end
            default:
                ;
        endcase
        result.size = shadow_count[SIZE_W-1:0];
        return result;
    endfunction

    // Present a request and hold it until accepted, then log its outcome.
    // A typed outcome replaces the predicted one, but the shadow still advances.
    task automatic offer_request(input opcode_t op, input data_t word,
                                 input logic [K_W-1:0] k, input logic typed,
                                 input queue_outcome_t typed_outcome);
        queue_outcome_t predicted;
        in_valid      <= 1'b1;
        opcode        <= op;
        push_value    <= word;
        prefix_length <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_queue(op, word, k);
        awaited_outcomes.push_back(typed ? typed_outcome : predicted);
    endtask

    // Between requests: either drain every outstanding result, drop valid
    // for a random gap at the end of a burst, or keep valid high.
    task automatic pace_sender(input logic drain);
        if (drain)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (awaited_outcomes.size() != 0);
        end
        else if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
            // Every fourth burst or so is long, giving stretches with no gaps.
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(10, 1);
        end
        else
            burst_left--;
    endtask

    task automatic report_mismatch(input string why, input queue_outcome_t want,
                                   input queue_outcome_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/data/size)",
                     $realtime, why, want.status, want.data, want.size,
                     got.status, got.data, got.size);
    endtask

    // Sender: directed table, then phased random traffic, then the end of run.
    initial
    begin
        traffic_phase_t phase;
        int             phase_left;
        int             pick;
        int             push_cut;
        int             pop_cut;
        int             peek_cut;
        int             size_cut;
        int             reverse_cut;
        opcode_t        op;
        data_t          word;
        logic [K_W-1:0] k;

        phase_left = 0;
        phase      = CHURN_PHASE;
        @(posedge rst_n);
        @(posedge clk);

        for (int row = 0; row < ROW_COUNT; row++)
        begin
            for (int rep = 0; rep < int'(directed_rows[row].reps); rep++)
            begin
                offer_request(directed_rows[row].op, directed_rows[row].word + rep,
                              directed_rows[row].k, directed_rows[row].typed,
                              directed_rows[row].outcome);
                // Drain after the table so random traffic starts from a quiet block.
                pace_sender(row == ROW_COUNT - 1 && rep == int'(directed_rows[row].reps) - 1);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Switch traffic phase now and then so the queue swings between
            // empty and full instead of hovering mid-way.
            if (phase_left == 0)
            begin
                phase      = traffic_phase_t'($urandom_range(CHURN_PHASE, FILL_PHASE));
                phase_left = $urandom_range(80, 20);
            end
            phase_left--;

            case (phase)
                FILL_PHASE:
                begin
                    push_cut = 60; pop_cut = 70; peek_cut = 75;
                    size_cut = 78; reverse_cut = 96;
                end
                DRAIN_PHASE:
                begin
                    push_cut = 15; pop_cut = 65; peek_cut = 72;
                    size_cut = 75; reverse_cut = 96;
                end
                default:
                begin
                    push_cut = 35; pop_cut = 60; peek_cut = 68;
                    size_cut = 72; reverse_cut = 96;
                end
            endcase

            pick = $urandom_range(99);
            if (pick < push_cut)
                op = OP_PUSH;
            else if (pick < pop_cut)
                op = OP_POP;
            else if (pick < peek_cut)
                op = OP_PEEK;
            else if (pick < size_cut)
                op = OP_SIZE;
            else if (pick < reverse_cut)
                op = OP_REVERSE;
            else
                op = opcode_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));

            word = $urandom;
            k    = K_W'($urandom_range(31));
            // Keep most reverses in range; the rest overshoot the count.
            if (op == OP_REVERSE)
            begin
                if ($urandom_range(99) < 85)
                    k = K_W'($urandom_range(shadow_count, 0));
                else
                    k = K_W'($urandom_range(31, shadow_count + 1));
            end

            offer_request(op, word, k, 1'b0, '0);
            // Pause once mid-run until every result is back, and drain at the end.
            pace_sender(n == RANDOM_ITEMS / 2 || n == RANDOM_ITEMS - 1);
        end

        // Let any trailing work in the block settle before judging.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_outcomes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: stall on a changing pattern, with two long hold-offs that
    // back the block up until it stalls its request channel.
    initial
    begin
        int holds_done;
        int mode;
        int stretch;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (holds_done < 2 &&
                outcomes_checked >= (holds_done == 0 ? FIRST_HOLD_AT : SECOND_HOLD_AT))
            begin
                out_stall <= 1'b1;
                for (int held = 0; held < HOLD_OFF_CYCLES; held++)
                    @(posedge clk);
                holds_done++;
            end
            mode    = $urandom_range(3);
            stretch = $urandom_range(60, 5);
            for (int step = 0; step < stretch; step++)
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= step[0];
                    2:       out_stall <= 1'($urandom_range(1));
                    default: out_stall <= (step % 4) != 0;
                endcase
                @(posedge clk);
            end
        end
    end

    // Check each accepted result against the oldest outstanding outcome.
    always @(posedge clk)
    begin
        queue_outcome_t got;
        queue_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, data_out, size_out};
            if (awaited_outcomes.size() == 0)
                report_mismatch("result with no request pending", '0, got);
            else
            begin
                want = awaited_outcomes.pop_front();
                if (got.status !== want.status || got.data !== want.data ||
                    got.size !== want.size)
                    report_mismatch("result differs", want, got);
            end
            outcomes_checked++;
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fqpr_pkg.sv
sv/fqpr_ctrl.sv
sv/fqpr_datapath.sv
sv/fifo_queue_with_prefix_reverse.sv
sv/fqpr_checker.sv
verif/testbench.sv
